@@ rtl/bldr_pkg.sv @@
// Shared types and constants for the line and depth rasterizer.
package bldr_pkg;

    localparam int COORD_W         = 6;
    localparam int COLOR_W         = 24;
    localparam int COUNT_W         = COORD_W + 1;
    localparam int ERR_W           = COORD_W + 3;
    localparam int SEG_QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OCT_VERT,
        OCT_HORZ,
        OCT_SHALLOW_UP,
        OCT_STEEP_UP,
        OCT_SHALLOW_DOWN,
        OCT_STEEP_DOWN
    } octant_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_RUN
    } back_state_t;

    // Geometry of one classified segment, as it sits in the queue.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        octant_t            octant;
        logic               depth_down;
        logic [COORD_W:0]   err_inc;
        logic [COORD_W-1:0] err_thr;
        logic [COUNT_W-1:0] pix_count;
        logic [COORD_W-1:0] span;
    } seg_geom_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

@@ rtl/bldr_if.sv @@
// Handshake interfaces for segments, pixels and the color register.
interface bldr_seg_if #(parameter int DEPTH_W = 24);
    logic                             valid;
    logic                             ready;
    logic [bldr_pkg::COORD_W-1:0]     start_x;
    logic [bldr_pkg::COORD_W-1:0]     start_y;
    logic signed [DEPTH_W-1:0]        start_depth;
    logic [bldr_pkg::COORD_W-1:0]     end_x;
    logic [bldr_pkg::COORD_W-1:0]     end_y;
    logic signed [DEPTH_W-1:0]        end_depth;

    modport source (output valid, start_x, start_y, start_depth, end_x, end_y, end_depth,
                    input ready);
    modport sink (input valid, start_x, start_y, start_depth, end_x, end_y, end_depth,
                  output ready);
endinterface

interface bldr_pix_if #(parameter int DEPTH_W = 24);
    logic                             valid;
    logic                             ready;
    logic [bldr_pkg::COORD_W-1:0]     pixel_x;
    logic [bldr_pkg::COORD_W-1:0]     pixel_y;
    logic signed [DEPTH_W-1:0]        pixel_depth;
    logic [bldr_pkg::COLOR_W-1:0]     pixel_color;
    logic                             last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_depth, pixel_color, last_pixel,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_depth, pixel_color, last_pixel,
                  output ready);
endinterface

interface bldr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bldr_pkg::COLOR_W-1:0]     line_color;

    modport source (output valid, line_color, input ready);
    modport sink (input valid, line_color, output ready);
endinterface

@@ rtl/bldr_front.sv @@
// Segment intake: hold one raw segment, clamp, order and classify it for the queue.
module bldr_front #(
    parameter int TILE_SIZE = 64,
    parameter int DEPTH_W   = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bldr_seg_if.sink              seg,
    input  bldr_pkg::queue_stat_t q_stat,
    output logic                  push,
    output bldr_pkg::seg_geom_t   geom,
    output logic [DEPTH_W-1:0]    z0,
    output logic [DEPTH_W-1:0]    dz_mag,
    output logic                  dz_neg
);

    localparam int CW = bldr_pkg::COORD_W;
    localparam logic [CW-1:0] TILE_MAX = CW'(TILE_SIZE - 1);

    logic                      hold_v_reg;
    logic [CW-1:0]             sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DEPTH_W-1:0] sz_reg, ez_reg;
    logic                      accept;

    logic [CW-1:0]             x0, y0, x1, y1;
    logic [CW-1:0]             xa, ya, xb, yb;
    logic signed [DEPTH_W-1:0] za, zb;
    logic                      swap;
    logic [CW-1:0]             dx, ady;
    logic                      dy_neg;
    logic signed [DEPTH_W:0]   zdiff, zdiff_neg;

    function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
        clamp = (v > TILE_MAX) ? TILE_MAX : v;
    endfunction

    assign seg.ready = !hold_v_reg || !q_stat.full;
    assign accept    = seg.valid && seg.ready;
    assign push      = hold_v_reg && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_v_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= seg.start_x;
            sy_reg <= seg.start_y;
            sz_reg <= seg.start_depth;
            ex_reg <= seg.end_x;
            ey_reg <= seg.end_y;
            ez_reg <= seg.end_depth;
        end
    end

    always_comb
    begin
        x0 = clamp(sx_reg);
        y0 = clamp(sy_reg);
        x1 = clamp(ex_reg);
        y1 = clamp(ey_reg);

        // Draw left to right: swap the endpoints, depths included.
        swap = x1 < x0;
        xa   = swap ? x1 : x0;
        ya   = swap ? y1 : y0;
        za   = swap ? ez_reg : sz_reg;
        xb   = swap ? x0 : x1;
        yb   = swap ? y0 : y1;
        zb   = swap ? sz_reg : ez_reg;

        dx     = xb - xa;
        dy_neg = yb < ya;
        ady    = dy_neg ? (ya - yb) : (yb - ya);

        zdiff     = (DEPTH_W + 1)'(zb) - (DEPTH_W + 1)'(za);
        zdiff_neg = -zdiff;
        dz_neg    = zdiff[DEPTH_W];
        dz_mag    = dz_neg ? zdiff_neg[DEPTH_W-1:0] : zdiff[DEPTH_W-1:0];
        z0        = za;

        geom.start_x    = xa;
        geom.start_y    = ya;
        geom.depth_down = 1'b0;
        if (dx == '0)
        begin
            // Vertical: every row from the low end up, far end included.
            geom.octant     = bldr_pkg::OCT_VERT;
            geom.start_y    = dy_neg ? yb : ya;
            geom.depth_down = dy_neg;
            geom.err_inc    = '0;
            geom.err_thr    = ady;
            geom.pix_count  = {1'b0, ady} + bldr_pkg::COUNT_W'(1);
            geom.span       = ady;
        end
        else if (ady <= dx)
        begin
            // Shallow, exact diagonal and horizontal: x is the major axis.
            if (ady == '0)
            begin
                geom.octant = bldr_pkg::OCT_HORZ;
            end
            else if (dy_neg)
            begin
                geom.octant = bldr_pkg::OCT_SHALLOW_DOWN;
            end
            else
            begin
                geom.octant = bldr_pkg::OCT_SHALLOW_UP;
            end
            geom.err_inc   = {ady, 1'b0};
            geom.err_thr   = dx;
            geom.pix_count = {1'b0, dx};
            geom.span      = dx;
        end
        else
        begin
            geom.octant    = dy_neg ? bldr_pkg::OCT_STEEP_DOWN : bldr_pkg::OCT_STEEP_UP;
            geom.err_inc   = {dx, 1'b0};
            geom.err_thr   = ady;
            geom.pix_count = {1'b0, ady};
            geom.span      = ady;
        end
    end

endmodule

@@ rtl/bldr_fifo.sv @@
// Small register queue between the segment classifier and the pixel walker.
module bldr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output bldr_pkg::queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.full  = count_reg == CNT_W'(DEPTH);
    assign stat.empty = count_reg == '0;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/bldr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bldr_div #(
    parameter int DW_N = 24,
    parameter int DV_N = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DW_N-1:0] dividend,
    input  logic [DV_N-1:0] divisor,
    output logic            done,
    output logic [DW_N-1:0] quotient,
    output logic [DV_N-1:0] remainder
);

    localparam int CNT_W = $clog2(DW_N + 1);

    logic [DW_N-1:0]  quo_reg;
    logic [DV_N-1:0]  rem_reg, div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DV_N:0]    trial, trial_sub;
    logic             ge;

    assign trial     = {rem_reg, quo_reg[DW_N-1]};
    assign ge        = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(DW_N);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DW_N-2:0], ge};
            rem_reg <= ge ? trial_sub[DV_N-1:0] : trial[DV_N-1:0];
        end
    end

endmodule

@@ rtl/bldr_back.sv @@
// Pixel walker: per-segment depth step division, then error-term stepping per pixel.
module bldr_back #(
    parameter int DEPTH_W = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bldr_pkg::queue_stat_t        q_stat,
    output logic                         pop,
    input  bldr_pkg::seg_geom_t          geom,
    input  logic [DEPTH_W-1:0]           z0,
    input  logic [DEPTH_W-1:0]           dz_mag,
    input  logic                         dz_neg,
    input  logic [bldr_pkg::COLOR_W-1:0] line_color,
    bldr_pix_if.source                   pix
);

    localparam int CW  = bldr_pkg::COORD_W;
    localparam int NW  = bldr_pkg::COUNT_W;
    localparam int EW  = bldr_pkg::ERR_W;
    localparam int DW  = DEPTH_W;

    bldr_pkg::back_state_t state_reg, state_next;
    bldr_pkg::octant_t     oct_reg, oct_next;
    logic [CW-1:0]         x_reg, x_next, y_reg, y_next;
    logic [CW:0]           inc_reg, inc_next;
    logic [CW-1:0]         thr_reg, thr_next, span_reg, span_next;
    logic [NW-1:0]         remain_reg, remain_next;
    logic signed [EW-1:0]  d_reg, d_next;
    logic                  down_reg, down_next, dzn_reg, dzn_next;
    logic [DW-1:0]         z0_reg, z0_next, qd_reg, qd_next, q_reg, q_next;
    logic [CW-1:0]         rd_reg, rd_next, r_reg, r_next;

    logic                  out_v_reg, out_v_next, out_last_reg, out_last_next;
    logic [CW-1:0]         out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [DW-1:0]         out_z_reg, out_z_next;
    logic [bldr_pkg::COLOR_W-1:0] out_c_reg, out_c_next;

    logic                  div_start, div_done;
    logic [DW-1:0]         div_quo;
    logic [CW-1:0]         div_rem;

    logic                  emit, last;
    logic signed [EW-1:0]  d_add, d_sub, thr_ext, thr2_ext;
    logic                  minor_step;
    logic [CW-1:0]         x_adv, y_adv;
    logic [CW:0]           r_up, r_up_sub, r_dn, r_dn_add;
    logic                  up_wrap, dn_borrow;
    logic [DW-1:0]         q_step;
    logic [CW-1:0]         r_step;
    logic signed [DW:0]    z_sum;

    bldr_div #(
        .DW_N (DW),
        .DV_N (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dz_mag),
        .divisor   (geom.span),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign pix.valid       = out_v_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_depth = out_z_reg;
    assign pix.pixel_color = out_c_reg;
    assign pix.last_pixel  = out_last_reg;

    // Error term: the minor axis advances only when the error exceeds the major span.
    always_comb
    begin
        thr_ext    = $signed(EW'(thr_reg));
        thr2_ext   = $signed(EW'({thr_reg, 1'b0}));
        d_add      = d_reg + $signed(EW'(inc_reg));
        d_sub      = d_add - thr2_ext;
        minor_step = d_add > thr_ext;

        x_adv = x_reg;
        y_adv = y_reg;
        unique case (oct_reg)
            bldr_pkg::OCT_VERT:
            begin
                y_adv = y_reg + 1'b1;
            end
            bldr_pkg::OCT_HORZ:
            begin
                x_adv = x_reg + 1'b1;
            end
            bldr_pkg::OCT_SHALLOW_UP:
            begin
                x_adv = x_reg + 1'b1;
                y_adv = minor_step ? y_reg + 1'b1 : y_reg;
            end
            bldr_pkg::OCT_STEEP_UP:
            begin
                y_adv = y_reg + 1'b1;
                x_adv = minor_step ? x_reg + 1'b1 : x_reg;
            end
            bldr_pkg::OCT_SHALLOW_DOWN:
            begin
                x_adv = x_reg + 1'b1;
                y_adv = minor_step ? y_reg - 1'b1 : y_reg;
            end
            bldr_pkg::OCT_STEEP_DOWN:
            begin
                y_adv = y_reg - 1'b1;
                x_adv = minor_step ? x_reg + 1'b1 : x_reg;
            end
            default:
            begin
                x_adv = x_reg + 1'b1;
            end
        endcase
    end

    // Depth quotient q and remainder r track offset*|dz| = q*span + r, stepped by one offset.
    always_comb
    begin
        r_up      = {1'b0, r_reg} + {1'b0, rd_reg};
        r_up_sub  = r_up - {1'b0, span_reg};
        up_wrap   = r_up >= {1'b0, span_reg};
        r_dn      = {1'b0, r_reg} - {1'b0, rd_reg};
        r_dn_add  = r_dn + {1'b0, span_reg};
        dn_borrow = r_dn[CW];
        if (down_reg)
        begin
            q_step = q_reg - qd_reg - DW'(dn_borrow);
            r_step = dn_borrow ? r_dn_add[CW-1:0] : r_dn[CW-1:0];
        end
        else
        begin
            q_step = q_reg + qd_reg + DW'(up_wrap);
            r_step = up_wrap ? r_up_sub[CW-1:0] : r_up[CW-1:0];
        end
        z_sum = (DW + 1)'($signed(z0_reg))
              + (dzn_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg}));
    end

    always_comb
    begin
        state_next    = state_reg;
        oct_next      = oct_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        inc_next      = inc_reg;
        thr_next      = thr_reg;
        span_next     = span_reg;
        remain_next   = remain_reg;
        d_next        = d_reg;
        down_next     = down_reg;
        dzn_next      = dzn_reg;
        z0_next       = z0_reg;
        qd_next       = qd_reg;
        rd_next       = rd_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_z_next    = out_z_reg;
        out_c_next    = out_c_reg;
        out_last_next = out_last_reg;
        pop           = 1'b0;
        div_start     = 1'b0;

        emit       = (state_reg == bldr_pkg::BK_RUN) && (!out_v_reg || pix.ready);
        last       = remain_reg == NW'(1);
        out_v_next = out_v_reg && !pix.ready;

        unique case (state_reg)
            bldr_pkg::BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop         = 1'b1;
                    oct_next    = geom.octant;
                    x_next      = geom.start_x;
                    y_next      = geom.start_y;
                    inc_next    = geom.err_inc;
                    thr_next    = geom.err_thr;
                    span_next   = geom.span;
                    remain_next = geom.pix_count;
                    down_next   = geom.depth_down;
                    dzn_next    = dz_neg;
                    z0_next     = z0;
                    d_next      = '0;
                    r_next      = '0;
                    q_next      = geom.depth_down ? dz_mag : '0;
                    if (geom.span == '0)
                    begin
                        // One-point segment: depth is z0, no division.
                        qd_next    = '0;
                        rd_next    = '0;
                        state_next = bldr_pkg::BK_RUN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = bldr_pkg::BK_DIV;
                    end
                end
            end
            bldr_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    qd_next    = div_quo;
                    rd_next    = div_rem;
                    state_next = bldr_pkg::BK_RUN;
                end
            end
            bldr_pkg::BK_RUN:
            begin
                if (emit)
                begin
                    out_v_next    = 1'b1;
                    out_x_next    = x_reg;
                    out_y_next    = y_reg;
                    out_z_next    = z_sum[DW-1:0];
                    out_c_next    = line_color;
                    out_last_next = last;
                    remain_next   = remain_reg - 1'b1;
                    x_next        = x_adv;
                    y_next        = y_adv;
                    d_next        = minor_step ? d_sub : d_add;
                    q_next        = q_step;
                    r_next        = r_step;
                    if (last)
                    begin
                        state_next = bldr_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bldr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bldr_pkg::BK_IDLE;
            out_v_reg  <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            out_v_reg  <= out_v_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oct_reg      <= oct_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        inc_reg      <= inc_next;
        thr_reg      <= thr_next;
        span_reg     <= span_next;
        d_reg        <= d_next;
        down_reg     <= down_next;
        dzn_reg      <= dzn_next;
        z0_reg       <= z0_next;
        qd_reg       <= qd_next;
        rd_reg       <= rd_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_z_reg    <= out_z_next;
        out_c_reg    <= out_c_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTH
    a_run_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bldr_pkg::BK_RUN |-> remain_reg != '0)
        else $error("walker running with no pixels left");

    a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (state_reg == bldr_pkg::BK_IDLE && out_v_reg && out_last_reg))
        else $error("last pixel did not close the segment");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == bldr_pkg::BK_DIV)
        else $error("divider finished outside the divide phase");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != bldr_pkg::BK_IDLE)
        else $error("segment popped but walker stayed idle");
`endif

endmodule

@@ rtl/bresenham_line_depth_rasterizer_core.sv @@
// Top level of the line rasterizer with depth interpolation.
// Takes one segment per transfer on seg and produces its pixels, one per transfer on pix, in
// drawing order (left to right; vertical segments from the smaller row up), each with
// position, depth z0 + offset*(z1-z0)/span truncated toward zero, the configured color and a
// last flag. The walker pops each segment, runs it through a serial divider that computes
// |z1-z0|/span once per segment, one quotient bit per cycle, then emits one pixel per
// cycle while pix takes them. A single-point segment skips the divider. Segments are
// accepted meanwhile into a holding register and a two-entry queue, so seg stalls only
// when both are full. Coordinates above TILE_SIZE-1 are saturated. The color register is
// written over cfg (always ready) and must only change while no segment is in flight.
module bresenham_line_depth_rasterizer_core #(
    parameter int TILE_SIZE   = 64,
    parameter int DEPTH_WIDTH = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    bldr_cfg_if.sink   cfg,
    bldr_seg_if.sink   seg,
    bldr_pix_if.source pix
);

    localparam int ENTRY_W = $bits(bldr_pkg::seg_geom_t) + 2 * DEPTH_WIDTH + 1;

    logic [bldr_pkg::COLOR_W-1:0] line_color_reg;

    // Front side of the queue
    bldr_pkg::seg_geom_t    f_geom;
    logic [DEPTH_WIDTH-1:0] f_z0, f_dz_mag;
    logic                   f_dz_neg;
    logic                   q_push;

    // Back side of the queue
    bldr_pkg::seg_geom_t    b_geom;
    logic [DEPTH_WIDTH-1:0] b_z0, b_dz_mag;
    logic                   b_dz_neg;
    logic                   q_pop;

    bldr_pkg::queue_stat_t  q_stat;
    logic [ENTRY_W-1:0]     q_wdata, q_rdata;

    // Color register: always ready, hold between writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_color_reg <= '0;
        end
        else if (cfg.valid)
        begin
            line_color_reg <= cfg.line_color;
        end
    end

    // Intake and classification
    bldr_front #(
        .TILE_SIZE (TILE_SIZE),
        .DEPTH_W   (DEPTH_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .seg    (seg),
        .q_stat (q_stat),
        .push   (q_push),
        .geom   (f_geom),
        .z0     (f_z0),
        .dz_mag (f_dz_mag),
        .dz_neg (f_dz_neg)
    );

    // Segment queue decouples intake from pixel walking.
    assign q_wdata = {f_geom, f_z0, f_dz_mag, f_dz_neg};
    assign {b_geom, b_z0, b_dz_mag, b_dz_neg} = q_rdata;

    bldr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (bldr_pkg::SEG_QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // Division and per-pixel stepping
    bldr_back #(
        .DEPTH_W (DEPTH_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .geom       (b_geom),
        .z0         (b_z0),
        .dz_mag     (b_dz_mag),
        .dz_neg     (b_dz_neg),
        .line_color (line_color_reg),
        .pix        (pix)
    );

endmodule

@@ bench/bldr_pixel_checker.sv @@
// Pixel stream checker: predicts every pixel of each accepted segment and compares.
module bldr_pixel_checker #(
    parameter int TILE_SIZE   = 64,
    parameter int DEPTH_WIDTH = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    bldr_cfg_if        cfg,
    bldr_seg_if        seg,
    bldr_pix_if        pix,
    output int         fail_count,
    output int         pending,
    output int         seg_total,
    output int         pixel_total,
    output logic [5:0] octants_seen
);

    localparam int CW = bldr_pkg::COORD_W;

    typedef struct packed {
        logic [CW-1:0]                  x;
        logic [CW-1:0]                  y;
        logic signed [DEPTH_WIDTH-1:0]  depth;
        logic [bldr_pkg::COLOR_W-1:0]   color;
        logic                           last;
    } pixel_t;

    pixel_t                       pixels_due[$];
    logic [bldr_pkg::COLOR_W-1:0] color_reg;
    int                           mismatches;
    int                           seg_count;
    int                           pix_count;
    logic [5:0]                   seen_mask;

    function automatic int clamp_coord(logic [CW-1:0] v);
        return (int'(v) > TILE_SIZE - 1) ? TILE_SIZE - 1 : int'(v);
    endfunction

    // Truncates toward zero, as SystemVerilog integer division does.
    function automatic longint depth_at(longint z0, longint z1, int off, int span);
        if (span == 0)
            return z0;
        return z0 + (longint'(off) * (z1 - z0)) / longint'(span);
    endfunction

    function automatic void add_pixel(int px, int py, longint z, bit last);
        pixel_t p;
        p.x     = px[CW-1:0];
        p.y     = py[CW-1:0];
        p.depth = z[DEPTH_WIDTH-1:0];
        p.color = color_reg;
        p.last  = last;
        pixels_due.push_back(p);
    endfunction

    // Walk one segment and queue its pixels in drawing order.
    function automatic void trace_segment(
        logic [CW-1:0] sx, logic [CW-1:0] sy, logic signed [DEPTH_WIDTH-1:0] sd,
        logic [CW-1:0] ex, logic [CW-1:0] ey, logic signed [DEPTH_WIDTH-1:0] ed);
        int                si_x0, y0, x1, y1, dx, dy, ady, d, x, y, t, lo, hi;
        longint            z0, z1, tz;
        bldr_pkg::octant_t oct;
        si_x0 = clamp_coord(sx);
        y0    = clamp_coord(sy);
        x1    = clamp_coord(ex);
        y1    = clamp_coord(ey);
        z0    = longint'(sd);
        z1    = longint'(ed);
        d     = 0;
        if (x1 < si_x0)
        begin
            t = si_x0; si_x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
            tz = z0; z0 = z1; z1 = tz;
        end
        dx  = x1 - si_x0;
        dy  = y1 - y0;
        ady = (dy < 0) ? -dy : dy;
        if (dx == 0)
        begin
            oct = bldr_pkg::OCT_VERT;
            lo  = (y0 < y1) ? y0 : y1;
            hi  = (y0 < y1) ? y1 : y0;
            for (y = lo; y <= hi; y++)
                add_pixel(si_x0, y, depth_at(z0, z1, y - y0, dy), y == hi);
        end
        else if (dy == 0)
        begin
            oct = bldr_pkg::OCT_HORZ;
            for (x = si_x0; x < x1; x++)
                add_pixel(x, y0, depth_at(z0, z1, x - si_x0, dx), x == x1 - 1);
        end
        else if (dy > 0 && ady <= dx)
        begin
            oct = bldr_pkg::OCT_SHALLOW_UP;
            y   = y0;
            for (x = si_x0; x < x1; x++)
            begin
                add_pixel(x, y, depth_at(z0, z1, x - si_x0, dx), x == x1 - 1);
                d += 2 * dy;
                if (d > dx)
                begin
                    d -= 2 * dx;
                    y++;
                end
            end
        end
        else if (dy > 0)
        begin
            oct = bldr_pkg::OCT_STEEP_UP;
            x   = si_x0;
            for (y = y0; y < y1; y++)
            begin
                add_pixel(x, y, depth_at(z0, z1, y - y0, dy), y == y1 - 1);
                d += 2 * dx;
                if (d > dy)
                begin
                    d -= 2 * dy;
                    x++;
                end
            end
        end
        else if (ady <= dx)
        begin
            oct = bldr_pkg::OCT_SHALLOW_DOWN;
            y   = y0;
            for (x = si_x0; x < x1; x++)
            begin
                add_pixel(x, y, depth_at(z0, z1, x - si_x0, dx), x == x1 - 1);
                d += 2 * ady;
                if (d > dx)
                begin
                    d -= 2 * dx;
                    y--;
                end
            end
        end
        else
        begin
            oct = bldr_pkg::OCT_STEEP_DOWN;
            x   = si_x0;
            for (y = y0; y > y1; y--)
            begin
                add_pixel(x, y, depth_at(z0, z1, y - y0, dy), y == y1 + 1);
                d += 2 * dx;
                if (d > ady)
                begin
                    d -= 2 * ady;
                    x++;
                end
            end
        end
        seen_mask[oct] = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t due;
        if (!rst_n)
        begin
            pixels_due.delete();
            color_reg    = '0;
            mismatches   = 0;
            seg_count    = 0;
            pix_count    = 0;
            seen_mask    = '0;
            fail_count   <= 0;
            pending      <= 0;
            seg_total    <= 0;
            pixel_total  <= 0;
            octants_seen <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                color_reg = cfg.line_color;
            // Check pixels before queueing a new segment so that a pixel can
            // never match a segment accepted on the same edge.
            if (pix.valid && pix.ready)
            begin
                pix_count++;
                if (pixels_due.size() == 0)
                begin
                    $error("pixel with nothing pending: x=%0d y=%0d", pix.pixel_x, pix.pixel_y);
                    mismatches++;
                end
                else
                begin
                    due = pixels_due.pop_front();
                    if (pix.pixel_x !== due.x)
                    begin
                        $error("pixel_x: expected %0d, actual %0d", due.x, pix.pixel_x);
                        mismatches++;
                    end
                    if (pix.pixel_y !== due.y)
                    begin
                        $error("pixel_y: expected %0d, actual %0d", due.y, pix.pixel_y);
                        mismatches++;
                    end
                    if (pix.pixel_depth !== due.depth)
                    begin
                        $error("pixel_depth: expected %0d, actual %0d",
                               $signed(due.depth), $signed(pix.pixel_depth));
                        mismatches++;
                    end
                    if (pix.pixel_color !== due.color)
                    begin
                        $error("pixel_color: expected %06h, actual %06h",
                               due.color, pix.pixel_color);
                        mismatches++;
                    end
                    if (pix.last_pixel !== due.last)
                    begin
                        $error("last_pixel: expected %0d, actual %0d", due.last, pix.last_pixel);
                        mismatches++;
                    end
                end
            end
            if (seg.valid && seg.ready)
            begin
                seg_count++;
                trace_segment(seg.start_x, seg.start_y, seg.start_depth,
                              seg.end_x, seg.end_y, seg.end_depth);
            end
            fail_count   <= mismatches;
            pending      <= pixels_due.size();
            seg_total    <= seg_count;
            pixel_total  <= pix_count;
            octants_seen <= seen_mask;
        end
    end

endmodule

@@ bench/bresenham_line_depth_rasterizer_core_tb.sv @@
// Top of the line rasterizer bench: clock, reset, segment stimulus, pacing and verdict.
module bresenham_line_depth_rasterizer_core_tb;

    localparam int TILE_SIZE        = 64;
    localparam int DEPTH_WIDTH      = 24;
    localparam int CW               = bldr_pkg::COORD_W;
    // Segments per random phase; three phases plus the directed set give ~420.
    localparam int RANDOM_PER_PHASE = 135;
    // Margin for the walker to go quiet, sized from its longest segment.
    localparam int TAIL_CYCLES      = 2 * (DEPTH_WIDTH + TILE_SIZE + 2);
    localparam int CYCLE_LIMIT      = 1_000_000;

    logic clk;
    logic rst_n;

    bldr_cfg_if                              cfg_ch ();
    bldr_seg_if #(.DEPTH_W(DEPTH_WIDTH))     seg_ch ();
    bldr_pix_if #(.DEPTH_W(DEPTH_WIDTH))     pix_ch ();

    int         fail_count;
    int         pixels_pending;
    int         seg_total;
    int         pixel_total;
    logic [5:0] octants_seen;

    int seg_gap_pct;
    int pix_stall_pct;
    int color_writes;
    int cycle_count = 0;

    bresenham_line_depth_rasterizer_core #(
        .TILE_SIZE   (TILE_SIZE),
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .seg   (seg_ch),
        .pix   (pix_ch)
    );

    bldr_pixel_checker #(
        .TILE_SIZE   (TILE_SIZE),
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) pixel_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_ch),
        .seg          (seg_ch),
        .pix          (pix_ch),
        .fail_count   (fail_count),
        .pending      (pixels_pending),
        .seg_total    (seg_total),
        .pixel_total  (pixel_total),
        .octants_seen (octants_seen)
    );

    // Free-running clock, period 2.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Pixel receiver: stall at random with the current phase's percentage.
    always @(posedge clk)
        pix_ch.ready <= ($urandom_range(0, 99) >= pix_stall_pct);

    // Watchdog: fail and end the run once the cycle limit is reached, as when the pixel stream hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL bresenham_line_depth_rasterizer_core");
            $finish;
        end
    end

    // Offer one segment, idling first at the sender's rate, and hold it until the
    // transfer. Leave valid high afterwards: the next call or settle() decides it.
    task automatic send_segment(
        logic [CW-1:0] sx, logic [CW-1:0] sy, logic signed [DEPTH_WIDTH-1:0] sd,
        logic [CW-1:0] ex, logic [CW-1:0] ey, logic signed [DEPTH_WIDTH-1:0] ed);
        while ($urandom_range(0, 99) < seg_gap_pct)
        begin
            seg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seg_ch.valid       <= 1'b1;
        seg_ch.start_x     <= sx;
        seg_ch.start_y     <= sy;
        seg_ch.start_depth <= sd;
        seg_ch.end_x       <= ex;
        seg_ch.end_y       <= ey;
        seg_ch.end_depth   <= ed;
        @(posedge clk);
        while (!seg_ch.ready)
            @(posedge clk);
    endtask

    // Depth mix: the two extremes, small values of either sign, and full-range noise.
    function automatic logic [DEPTH_WIDTH-1:0] pick_depth();
        case ($urandom_range(0, 7))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'(-int'($urandom_range(0, 300)));
            3:       return 24'($urandom_range(0, 300));
            default: return 24'($urandom);
        endcase
    endfunction

    // Coordinate within four of c, held inside the tile.
    function automatic logic [CW-1:0] near(logic [CW-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > TILE_SIZE - 1)
            v = TILE_SIZE - 1;
        return v[CW-1:0];
    endfunction

    // Random segment: mostly general lines of any octant, plus single points,
    // axis-aligned runs and short strokes.
    task automatic random_segment();
        logic [CW-1:0] sx, sy, ex, ey;
        int            kind;
        kind = $urandom_range(0, 19);
        sx   = 6'($urandom);
        sy   = 6'($urandom);
        ex   = 6'($urandom);
        ey   = 6'($urandom);
        case (kind)
            0:       begin ex = sx; ey = sy; end
            1, 2:    ex = sx;
            3, 4:    ey = sy;
            5, 6, 7: begin ex = near(sx); ey = near(sy); end
            default: ;
        endcase
        send_segment(sx, sy, pick_depth(), ex, ey, pick_depth());
    endtask

    // Drop valid, wait for every predicted pixel, then let the walker go quiet.
    task automatic settle();
        seg_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write the color register; only called with nothing in flight.
    task automatic write_color(logic [bldr_pkg::COLOR_W-1:0] c);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.line_color <= c;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        color_writes++;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.line_color  <= '0;
        seg_ch.valid       <= 1'b0;
        seg_ch.start_x     <= '0;
        seg_ch.start_y     <= '0;
        seg_ch.start_depth <= '0;
        seg_ch.end_x       <= '0;
        seg_ch.end_y       <= '0;
        seg_ch.end_depth   <= '0;
        color_writes       = 0;
        seg_gap_pct        = 16;
        pix_stall_pct      = 51;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender idles lightly, receiver stalls about half the time.
        write_color(24'hFFFFFF);

        // Single points at both corners; depth must come out as the start depth.
        send_segment(6'd0,  6'd0,  24'sd0,      6'd0,  6'd0,  24'sd0);
        send_segment(6'd63, 6'd63, 24'h7FFFFF,  6'd63, 6'd63, 24'h800000);
        // Vertical, full height, both directions (inclusive of the far end).
        send_segment(6'd0,  6'd0,  24'h800000,  6'd0,  6'd63, 24'h7FFFFF);
        send_segment(6'd63, 6'd63, 24'h7FFFFF,  6'd63, 6'd0,  24'h800000);
        // Horizontal, full width, then one that needs the endpoint swap.
        send_segment(6'd0,  6'd0,  24'h800000,  6'd63, 6'd0,  24'h7FFFFF);
        send_segment(6'd63, 6'd40, 24'sd100,    6'd0,  6'd40, -24'sd100);
        send_segment(6'd7,  6'd7,  24'sd9,      6'd8,  6'd7,  24'sd1);
        // Exact diagonals count as shallow.
        send_segment(6'd0,  6'd0,  24'sd0,      6'd63, 6'd63, 24'h7FFFFF);
        send_segment(6'd0,  6'd63, 24'h800000,  6'd63, 6'd0,  24'sd0);
        send_segment(6'd63, 6'd63, 24'sd1000,   6'd0,  6'd0,  -24'sd1000);
        send_segment(6'd7,  6'd7,  -24'sd3,     6'd8,  6'd8,  24'sd3);
        // One of each sloped octant, plus swapped steep ones.
        send_segment(6'd0,  6'd10, 24'sd5000,   6'd60, 6'd30, -24'sd5000);
        send_segment(6'd5,  6'd0,  24'sd12345,  6'd20, 6'd63, 24'sd777);
        send_segment(6'd0,  6'd50, -24'sd4000,  6'd63, 6'd20, 24'sd65536);
        send_segment(6'd10, 6'd63, 24'sd65536,  6'd30, 6'd0,  -24'sd65536);
        send_segment(6'd30, 6'd0,  24'sd2,      6'd10, 6'd63, 24'sd200);
        send_segment(6'd20, 6'd63, 24'h7FFFFF,  6'd5,  6'd0,  24'h800000);
        // Error exactly at the major span must not step the minor axis.
        send_segment(6'd0,  6'd0,  24'sd0,      6'd4,  6'd2,  24'sd8);
        send_segment(6'd0,  6'd0,  24'sd0,      6'd2,  6'd4,  24'sd8);
        send_segment(6'd40, 6'd20, 24'sd0,      6'd44, 6'd18, 24'sd8);
        // Negative quotients truncate toward zero.
        send_segment(6'd0,  6'd0,  24'sd0,      6'd3,  6'd0,  -24'sd5);
        send_segment(6'd0,  6'd0,  24'h800000,  6'd63, 6'd1,  24'h7FFFFF);

        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            random_segment();
        settle();

        // Phase 2: sender idles about half the time, receiver stalls lightly.
        write_color(24'h000000);
        seg_gap_pct   = 51;
        pix_stall_pct = 16;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            random_segment();
        settle();

        // Phase 3: no idling on either side, so the walker runs back to back.
        write_color(24'($urandom));
        seg_gap_pct   = 0;
        pix_stall_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            random_segment();
        settle();

        $display("Coverage: %0d segments, %0d pixels, %0d color settings, three pacing phases",
                 seg_total, pixel_total, color_writes);
        $display("Octant classes reached (vertical in bit 0): %b", octants_seen);
        if (fail_count == 0)
            $display("PASS bresenham_line_depth_rasterizer_core");
        else
            $display("FAIL bresenham_line_depth_rasterizer_core");
        $finish;
    end

endmodule
